FILE: sv/zexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zexp_pkg
// shared types, register indexes and step functions of the z-expansion unit
// ----------------------------------------------------------------------------
package zexp_pkg;

    localparam int MAX_TERMS = 5;
    localparam int ORD_W     = (MAX_TERMS > 2) ? $clog2(MAX_TERMS) : 1;
    localparam int HN        = MAX_TERMS - 1;   // horner steps
    localparam int SQ_STEPS  = 28;              // root bits
    localparam int DV_STEPS  = 30;              // quotient bits below one
    localparam int CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER  = 4'd0,
        REG_CUT    = 4'd1,
        REG_ORIGIN = 4'd2,
        REG_COEF0  = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] a1;
        logic [31:0] a0;
        logic [29:0] r1;
        logic [29:0] r0;
        logic [27:0] q1;
        logic [27:0] q0;
        logic        bad;
    } sq_t;

    typedef struct packed {
        logic [28:0] den;
        logic [28:0] rem;
        logic [29:0] q;
        logic        neg;
        logic        eq;
        logic        bad;
    } dv_t;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] acc;
        logic signed [63:0] prod;
        logic               bad;
    } hn_t;

    typedef struct packed {
        logic [29:0] rem;
        logic [27:0] root;
    } sqs_t;

    // one bit of a restoring square root
    function automatic sqs_t sqrt_step(input logic [29:0] rem, input logic [27:0] root,
                                       input logic [1:0] pair);
        logic [29:0] sh;
        logic [29:0] trial;
        sqs_t        r;
        sh    = {rem[27:0], pair};
        trial = {root, 2'b01};
        if (sh >= trial)
        begin
            r.rem  = sh - trial;
            r.root = {root[26:0], 1'b1};
        end
        else
        begin
            r.rem  = sh;
            r.root = {root[26:0], 1'b0};
        end
        return r;
    endfunction

    // saturate a 35-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

FILE: sv/z_expansion_form_factor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z_expansion_form_factor_unit
// z-expansion axial form factor: conformal map of q2, then horner polynomial
// ----------------------------------------------------------------------------
// Takes one q2 word (signed Q8.24) per cycle and returns F = sum a_k z^k with
// z = (sqrt(tcut-q2) - sqrt(tcut-t0)) / (sqrt(tcut-q2) + sqrt(tcut-t0)) in
// Q1.30, saturated to signed Q8.24. A negative root argument or a zero
// denominator gives F = 0 with undefined_flag set. Throughput is one word per
// cycle unless halted. Stages: input, 28 square-root (one root bit each, both
// roots side by side), divider set-up, divider (one quotient bit each), 9
// horner (head, then multiply and round/add per term), output register. The
// pipe moves as a whole, halting only while a finished word waits in the
// output register under stall. Write registers with cfg_valid/cfg_ready only
// while the pipe is empty (unenforced by the block); cfg_ready is always high.
// ----------------------------------------------------------------------------
module z_expansion_form_factor_unit
    import zexp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   momentum_sq,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   form_factor,
    output logic                 undefined_flag
);

    localparam logic [2:0] ORD_MAX3 = 3'(MAX_TERMS - 1);

    // configuration registers
    logic [2:0]         max_order_reg;
    logic [30:0]        cut_value_reg;
    logic signed [31:0] origin_value_reg;
    logic signed [31:0] coef_reg [MAX_TERMS];
    logic [ORD_W-1:0]   order_c;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_order_reg    <= 3'd4;
            cut_value_reg    <= 31'd2962856;
            origin_value_reg <= -32'sd4697620;
            for (int k = 0; k < MAX_TERMS; k++)
                coef_reg[k] <= '0;
        end
        else if (cfg_valid)
        begin
            priority if (cfg_index == REG_ORDER)
                max_order_reg <= cfg_data[2:0];
            else if (cfg_index == REG_CUT)
                cut_value_reg <= cfg_data[30:0];
            else if (cfg_index == REG_ORIGIN)
                origin_value_reg <= cfg_data;
            else if (cfg_index >= REG_COEF0
                     && cfg_index < CFG_IDX_W'(int'(REG_COEF0) + MAX_TERMS))
                coef_reg[ORD_W'(cfg_index - REG_COEF0)] <= cfg_data;
        end
    end

    // orders beyond the coefficient slots use the top slot
    assign order_c = (max_order_reg > ORD_MAX3) ? ORD_W'(ORD_MAX3)
                                                : ORD_W'(max_order_reg);

    // whole-pipe advance: halt only when a finished word is stalled
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // ---------------- input stage: root arguments ----------------
    logic signed [33:0] arg1;
    logic signed [33:0] arg0;
    sq_t                sq_reg [SQ_STEPS+1];
    logic               sq_v_reg [SQ_STEPS+1];

    assign arg1 = $signed({3'b000, cut_value_reg}) - {{2{momentum_sq[31]}}, momentum_sq};
    assign arg0 = $signed({3'b000, cut_value_reg})
                  - {{2{origin_value_reg[31]}}, origin_value_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (adv)
            sq_v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0].a1  <= arg1[31:0];
            sq_reg[0].a0  <= arg0[31:0];
            sq_reg[0].r1  <= '0;
            sq_reg[0].r0  <= '0;
            sq_reg[0].q1  <= '0;
            sq_reg[0].q0  <= '0;
            sq_reg[0].bad <= arg1[33] || arg0[33];
        end
    end

    // ---------------- square roots, one bit per stage ----------------
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sq
        logic [55:0] rad1;
        logic [55:0] rad0;
        sqs_t        st1;
        sqs_t        st0;

        assign rad1 = {sq_reg[i].a1, 24'b0};
        assign rad0 = {sq_reg[i].a0, 24'b0};
        assign st1  = sqrt_step(sq_reg[i].r1, sq_reg[i].q1, rad1[55-2*i -: 2]);
        assign st0  = sqrt_step(sq_reg[i].r0, sq_reg[i].q0, rad0[55-2*i -: 2]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[i+1] <= 1'b0;
            else if (adv)
                sq_v_reg[i+1] <= sq_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[i+1].a1  <= sq_reg[i].a1;
                sq_reg[i+1].a0  <= sq_reg[i].a0;
                sq_reg[i+1].r1  <= st1.rem;
                sq_reg[i+1].r0  <= st0.rem;
                sq_reg[i+1].q1  <= st1.root;
                sq_reg[i+1].q0  <= st0.root;
                sq_reg[i+1].bad <= sq_reg[i].bad;
            end
        end
    end

    // ---------------- divider set-up: sum, difference, sign ----------------
    logic [27:0] s1;
    logic [27:0] s0;
    logic [28:0] den;
    logic [27:0] diff;
    logic        neg;
    dv_t         dv_reg [DV_STEPS+1];
    logic        dv_v_reg [DV_STEPS+1];

    assign s1   = sq_reg[SQ_STEPS].q1;
    assign s0   = sq_reg[SQ_STEPS].q0;
    assign den  = {1'b0, s1} + {1'b0, s0};
    assign neg  = s1 < s0;
    assign diff = neg ? (s0 - s1) : (s1 - s0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (adv)
            dv_v_reg[0] <= sq_v_reg[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0].den <= den;
            dv_reg[0].rem <= {1'b0, diff};
            dv_reg[0].q   <= '0;
            dv_reg[0].neg <= neg;
            // one root zero: |z| is exactly one
            dv_reg[0].eq  <= ({1'b0, diff} == den);
            dv_reg[0].bad <= sq_reg[SQ_STEPS].bad || (den == '0);
        end
    end

    // ---------------- restoring division, one quotient bit per stage ----------------
    for (genvar i = 0; i < DV_STEPS; i++)
    begin : g_dv
        logic [29:0] sh;
        logic        ge;

        assign sh = {dv_reg[i].rem, 1'b0};
        assign ge = sh >= {1'b0, dv_reg[i].den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[i+1] <= 1'b0;
            else if (adv)
                dv_v_reg[i+1] <= dv_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[i+1].den <= dv_reg[i].den;
                dv_reg[i+1].rem <= ge ? 29'(sh - {1'b0, dv_reg[i].den}) : sh[28:0];
                dv_reg[i+1].q   <= {dv_reg[i].q[28:0], ge};
                dv_reg[i+1].neg <= dv_reg[i].neg;
                dv_reg[i+1].eq  <= dv_reg[i].eq;
                dv_reg[i+1].bad <= dv_reg[i].bad;
            end
        end
    end

    // ---------------- horner head: signed z and top coefficient ----------------
    logic [30:0]        zmag;
    logic signed [31:0] z_s;
    hn_t                hn_reg [2*HN+1];
    logic               hn_v_reg [2*HN+1];

    assign zmag = dv_reg[DV_STEPS].eq ? 31'h40000000 : {1'b0, dv_reg[DV_STEPS].q};
    assign z_s  = dv_reg[DV_STEPS].neg ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hn_v_reg[0] <= 1'b0;
        else if (adv)
            hn_v_reg[0] <= dv_v_reg[DV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hn_reg[0].z    <= z_s;
            hn_reg[0].acc  <= coef_reg[order_c];
            hn_reg[0].prod <= '0;
            hn_reg[0].bad  <= dv_reg[DV_STEPS].bad;
        end
    end

    // ---------------- horner steps: multiply stage, then round/add stage ----------------
    for (genvar j = 0; j < HN; j++)
    begin : g_hn
        localparam int K = HN - 1 - j;
        logic signed [63:0] rnd;
        logic signed [34:0] sum;
        logic               act;

        assign rnd = hn_reg[2*j+1].prod + 64'sd536870912;
        assign sum = 35'(rnd >>> 30) + 35'(coef_reg[K]);
        // terms above the programmed order pass through
        assign act = ORD_W'(K) < order_c;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hn_v_reg[2*j+1] <= 1'b0;
                hn_v_reg[2*j+2] <= 1'b0;
            end
            else if (adv)
            begin
                hn_v_reg[2*j+1] <= hn_v_reg[2*j];
                hn_v_reg[2*j+2] <= hn_v_reg[2*j+1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hn_reg[2*j+1].z    <= hn_reg[2*j].z;
                hn_reg[2*j+1].acc  <= hn_reg[2*j].acc;
                hn_reg[2*j+1].prod <= hn_reg[2*j].acc * hn_reg[2*j].z;
                hn_reg[2*j+1].bad  <= hn_reg[2*j].bad;

                hn_reg[2*j+2].z    <= hn_reg[2*j+1].z;
                hn_reg[2*j+2].acc  <= act ? sat32(sum) : hn_reg[2*j+1].acc;
                hn_reg[2*j+2].prod <= hn_reg[2*j+1].prod;
                hn_reg[2*j+2].bad  <= hn_reg[2*j+1].bad;
            end
        end
    end

    // ---------------- output register ----------------
    logic signed [31:0] form_factor_reg;
    logic               undefined_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= hn_v_reg[2*HN];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            form_factor_reg    <= hn_reg[2*HN].bad ? '0 : hn_reg[2*HN].acc;
            undefined_flag_reg <= hn_reg[2*HN].bad;
        end
    end

    assign out_valid      = out_valid_reg;
    assign form_factor    = form_factor_reg;
    assign undefined_flag = undefined_flag_reg;

endmodule
